FILE: rtl/rled_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rled_pkg;

  // fixed field widths
  localparam int BYTE_W    = 8;
  localparam int DATA_W    = 64;
  localparam int MAX_LANES = DATA_W / BYTE_W;
  localparam int COUNT_W   = 4;
  localparam int STATUS_W  = 3;
  localparam int EXP_W     = 24;

  // tag decoding
  localparam logic [7:0] REP_FLAG = 8'h80;
  localparam logic [6:0] REP_MASK = 7'h7f;
  localparam logic [7:0] REP_BIAS = 8'd3;

  // chunk status codes
  localparam logic [STATUS_W-1:0] ST_BUSY  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_GOOD  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TRUNC = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SHORT = 3'd4;

  // commands from controller to datapath
  typedef struct packed {
    logic take_item;
    logic load_word;
    logic use_burst;
  } ctl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic has_result;
    logic item_more;
    logic burst_more;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/rled_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rled_ctrl import rled_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     enc_valid,
  output logic          enc_stall,
  output logic          res_valid,
  input  wire logic     res_stall,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  typedef enum logic {
    S_IDLE,
    S_BURST
  } state_t;

  state_t state;
  state_t state_next;
  logic   res_valid_next;
  logic   out_free;

  // output register can take a word this cycle
  assign out_free = !res_valid || !res_stall;

  // command decode and next state
  always_comb begin
    state_next    = state;
    cmd.take_item = 1'b0;
    cmd.load_word = 1'b0;
    cmd.use_burst = 1'b0;
    enc_stall     = 1'b1;
    case (state)
      S_IDLE: begin
        enc_stall     = !out_free;
        cmd.take_item = enc_valid && out_free;
        cmd.load_word = cmd.take_item && stat.has_result;
        if (cmd.take_item && stat.item_more) begin
          state_next = S_BURST;
        end
      end
      S_BURST: begin
        cmd.use_burst = 1'b1;
        cmd.load_word = out_free;
        if (out_free && !stat.burst_more) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res_valid_next = cmd.load_word || (res_valid && res_stall);
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rled_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module rled_dp import rled_pkg::*; #(
  parameter int SIZE_WIDTH = 24,
  parameter int OUT_BYTES  = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ctl_cmd_t            cmd,
  output dp_stat_t                 stat,
  input  wire logic [BYTE_W-1:0]   enc_byte,
  input  wire logic                chunk_last,
  input  wire logic [EXP_W-1:0]    expected_size,
  input  wire logic                codec_raw,
  output logic [DATA_W-1:0]        out_data,
  output logic [COUNT_W-1:0]       out_count,
  output logic [STATUS_W-1:0]      status,
  output logic                     end_of_chunk,
  output logic                     run_last
);

  localparam logic [7:0] LANES = 8'(OUT_BYTES);

  typedef enum logic [1:0] {
    PH_START,
    PH_TAG,
    PH_LIT,
    PH_REP
  } phase_t;

  // decode state
  phase_t                phase;
  phase_t                phase_next;
  logic [7:0]            literal_left;
  logic [7:0]            literal_left_next;
  logic [SIZE_WIDTH-1:0] remaining;
  logic [SIZE_WIDTH-1:0] remaining_next;
  logic                  raw_mode;
  logic                  raw_mode_next;
  logic [STATUS_W-1:0]   error_code;
  logic [STATUS_W-1:0]   error_code_next;
  logic [7:0]            repeat_length;
  logic [7:0]            repeat_length_next;

  // burst state for words still owed by the current item
  logic [7:0]            burst_left;
  logic [BYTE_W-1:0]     burst_byte;
  logic                  burst_end;
  logic [STATUS_W-1:0]   burst_status;

  // fresh item decode
  logic [7:0]            emit_len;
  logic [7:0]            tag_len;
  logic [STATUS_W-1:0]   chunk_status;

  // word former
  logic [7:0]            src_len;
  logic [BYTE_W-1:0]     src_byte;
  logic                  src_end;
  logic [STATUS_W-1:0]   src_status;
  logic [7:0]            word_bytes;
  logic [7:0]            rest;
  logic [DATA_W-1:0]     word_data;
  logic                  word_final;

  // decode one encoded byte against the chunk state
  always_comb begin
    phase_next         = phase;
    literal_left_next  = literal_left;
    remaining_next     = remaining;
    raw_mode_next      = raw_mode;
    error_code_next    = error_code;
    repeat_length_next = repeat_length;
    emit_len           = 8'd0;
    tag_len            = 8'd0;
    chunk_status       = ST_BUSY;

    // chunk start samples size and codec
    if (phase == PH_START) begin
      remaining_next     = SIZE_WIDTH'(expected_size);
      raw_mode_next      = codec_raw;
      error_code_next    = ST_BUSY;
      literal_left_next  = 8'd0;
      repeat_length_next = 8'd0;
      phase_next         = PH_TAG;
    end

    if (error_code_next != ST_BUSY) begin
      // discard until chunk end
    end else if (raw_mode_next) begin
      if (remaining_next == '0) begin
        error_code_next = ST_OVER;
      end else begin
        emit_len       = 8'd1;
        remaining_next = remaining_next - SIZE_WIDTH'(1);
      end
    end else if (phase_next == PH_LIT) begin
      emit_len          = 8'd1;
      remaining_next    = remaining_next - SIZE_WIDTH'(1);
      literal_left_next = literal_left_next - 8'd1;
      if (literal_left_next == 8'd0) begin
        phase_next = PH_TAG;
      end
    end else if (phase_next == PH_REP) begin
      emit_len       = repeat_length_next;
      remaining_next = remaining_next - SIZE_WIDTH'(repeat_length_next);
      phase_next     = PH_TAG;
    end else begin
      if ((enc_byte & REP_FLAG) != 8'd0) begin
        tag_len            = {1'b0, enc_byte[6:0] & REP_MASK} + REP_BIAS;
        repeat_length_next = tag_len;
        phase_next         = PH_REP;
      end else begin
        tag_len           = enc_byte + 8'd1;
        literal_left_next = tag_len;
        phase_next        = PH_LIT;
      end
      if (!chunk_last && (SIZE_WIDTH'(tag_len) > remaining_next)) begin
        error_code_next = ST_OVER;
      end
    end

    // final status on the chunk's last byte
    if (chunk_last) begin
      if (error_code_next != ST_BUSY) begin
        chunk_status = error_code_next;
      end else if (!raw_mode_next && (phase_next == PH_LIT || phase_next == PH_REP)) begin
        chunk_status = ST_TRUNC;
      end else if (remaining_next != '0) begin
        chunk_status = ST_SHORT;
      end else begin
        chunk_status = ST_GOOD;
      end
      error_code_next   = (chunk_status == ST_GOOD) ? ST_BUSY : chunk_status;
      phase_next        = PH_START;
      literal_left_next = 8'd0;
    end
  end

  // word former shared by the fresh item and the burst
  always_comb begin
    src_len    = cmd.use_burst ? burst_left : emit_len;
    src_byte   = cmd.use_burst ? burst_byte : enc_byte;
    src_end    = cmd.use_burst ? burst_end : chunk_last;
    src_status = cmd.use_burst ? burst_status : chunk_status;
    word_bytes = (src_len >= LANES) ? LANES : src_len;
    rest       = src_len - word_bytes;
    word_final = (rest == 8'd0);
    word_data  = '0;
    for (int i = 0; i < MAX_LANES; i++) begin
      if (8'(i) < word_bytes) begin
        word_data[i*BYTE_W +: BYTE_W] = src_byte;
      end
    end
  end

  // more words owed, for a fresh item and for a running burst
  assign stat.has_result = (emit_len != 8'd0) || chunk_last;
  assign stat.item_more  = (emit_len > LANES);
  assign stat.burst_more = (burst_left > LANES);

  // decode state update on each item transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      literal_left  <= 8'd0;
      remaining     <= '0;
      raw_mode      <= 1'b0;
      error_code    <= ST_BUSY;
      repeat_length <= 8'd0;
    end else if (cmd.take_item) begin
      phase         <= phase_next;
      literal_left  <= literal_left_next;
      remaining     <= remaining_next;
      raw_mode      <= raw_mode_next;
      error_code    <= error_code_next;
      repeat_length <= repeat_length_next;
    end
  end

  // burst registers and output word
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      burst_byte   <= enc_byte;
      burst_end    <= chunk_last;
      burst_status <= chunk_status;
    end
    if (cmd.load_word) begin
      burst_left   <= rest;
      out_data     <= word_data;
      out_count    <= word_bytes[COUNT_W-1:0];
      end_of_chunk <= word_final && src_end;
      status       <= (word_final && src_end) ? src_status : ST_BUSY;
      run_last     <= word_final;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rle_byte_decoder_unit.sv
// Byte run-length decoder. One encoded byte enters per transfer on the enc
// channel (enc_valid / enc_stall) with chunk_last; expected_size and
// codec_raw are sampled on a chunk's first byte. Decoded bytes leave on the
// res channel (res_valid / res_stall) as packed words of up to OUT_BYTES
// bytes, lowest byte first, with out_count, status, end_of_chunk and
// run_last. The chunk's final status rides on its last result; a byte that
// ends a chunk without data gives a status-only result of zero bytes.
// Latency: a result is shown in the cycle after its byte is taken.
// Raw and literal bytes, and tags, are taken back to back while the output
// register drains. A repeat byte for a run of n copies (up to 130) leaves
// as words of up to OUT_BYTES bytes: the single output register emits one
// word per cycle while res is not stalled, and input is stalled meanwhile.
// A stall on res holds the current result and stalls enc in turn.
// Synchronous reset empties the output register and returns the decoder to
// the start of a chunk.
`timescale 1ns / 1ps
`default_nettype none

module rle_byte_decoder_unit import rled_pkg::*; #(
  parameter int SIZE_WIDTH = 24,
  parameter int OUT_BYTES  = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                enc_valid,
  output logic                     enc_stall,
  input  wire logic [BYTE_W-1:0]   enc_byte,
  input  wire logic                chunk_last,
  input  wire logic [EXP_W-1:0]    expected_size,
  input  wire logic                codec_raw,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output logic [DATA_W-1:0]        out_data,
  output logic [COUNT_W-1:0]       out_count,
  output logic [STATUS_W-1:0]      status,
  output logic                     end_of_chunk,
  output logic                     run_last
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencing of transfers and output bursts
  rled_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .enc_valid (enc_valid),
    .enc_stall (enc_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // decode state, burst and output word
  rled_dp #(
    .SIZE_WIDTH (SIZE_WIDTH),
    .OUT_BYTES  (OUT_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .enc_byte      (enc_byte),
    .chunk_last    (chunk_last),
    .expected_size (expected_size),
    .codec_raw     (codec_raw),
    .out_data      (out_data),
    .out_count     (out_count),
    .status        (status),
    .end_of_chunk  (end_of_chunk),
    .run_last      (run_last)
  );

endmodule

`default_nettype wire
